FILE: src/fixed_block_pool_allocator_macros.svh
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FBPA_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define FBPA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: src/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Sizes, types, codes and FSM states for the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int MAX_BLOCKS = 64;

	// bitmap rows
	localparam int WORD_W    = 16;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int LIM_W  = (CNT_W > 7) ? CNT_W : 7;
	localparam int PROD_W = IDX_W + 16;

	// divider: 32 / 16, radix 16
	localparam int DIV_BITS_PER_CYC = 4;
	localparam int DIV_CYCLES       = 32 / DIV_BITS_PER_CYC;
	localparam int DIV_CNT_W        = $clog2(DIV_CYCLES);

	// request commands
	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	// register indexes
	typedef enum logic {
		REG_BLOCK_BYTES   = 1'b0,
		REG_BLOCKS_IN_USE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic               en;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  data;
	} ram_wr_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ARD,
		ST_ACHK,
		ST_MUL,
		ST_RES,
		ST_DIV,
		ST_FRD,
		ST_FCHK
	} state_t;

endpackage

FILE: src/fbpa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// fbpa_bitmap_ram
// Used-bit memory, one row of WORD_W blocks per address, registered read.
// Rows never written read as zero via per-row valid bits.
// ----------------------------------------------------------------------------
module fbpa_bitmap_ram
	import fbpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [WADDR_W-1:0] rd_addr,
	input  ram_wr_t            wr,
	output logic [WORD_W-1:0]  rd_data
);

	logic [WORD_W-1:0]    mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] row_vld_q;
	logic [WORD_W-1:0]    rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr.en) begin
			row_vld_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= row_vld_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: src/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring 32 / 16 divider, four quotient bits a cycle.
// A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module fbpa_div
	import fbpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output div_res_t    res
);

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [15:0]          dvs_q;
	logic [15:0]          rem_q;
	logic [31:0]          quo_q;
	logic [15:0]          rem_d;
	logic [31:0]          quo_d;

	always_comb begin
		logic [16:0] r17;
		logic [15:0] r;
		logic [31:0] q;
		r = rem_q;
		q = quo_q;
		for (int k = 0; k < DIV_BITS_PER_CYC; k++) begin
			r17 = {1'b0, r};
			r17 = {r17[15:0], q[31]};
			q   = {q[30:0], 1'b0};
			if (r17 >= {1'b0, dvs_q}) begin
				r17  = r17 - {1'b0, dvs_q};
				q[0] = 1'b1;
			end
			r = r17[15:0];
		end
		rem_d = r;
		quo_d = q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;

endmodule

FILE: src/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a used bitmap held in a synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive command/free_offset and raise start; the request
//   is taken on a clock edge with start high and busy low. Commands: 0
//   allocates the lowest free block below the block count, 1 frees the block
//   holding free_offset (offset / block_bytes, remainder dropped).
//   Result channel: done pulses for one cycle with ok, block_offset and
//   used_count. The receiver cannot stall; each result is shown once.
//   Flow: one request at a time. An allocate walks the bitmap one row of
//   16 blocks at a time (read state then check state); a hit adds a multiply
//   state and a result state before done, and a failed search ends at the
//   check of the last row. A free runs the radix-16 divider, then one read
//   and one check of the bitmap row before done; when the index is out of
//   range, done follows the divider with no read. A new request may be
//   accepted at the edge that ends the done cycle.
//   Config: APB write at 0 sets block_bytes, at 4 sets blocks_in_use
//   (its use is clamped to MAX_BLOCKS); write only while idle.
//   Reset: bitmap reads all free (row valid bits clear), count zero,
//   block_bytes 64, blocks_in_use 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_macros.svh"

module fixed_block_pool_allocator
	import fbpa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] free_offset,
	// result
	output logic        done,
	output logic        ok,
	output logic [21:0] block_offset,
	output logic [6:0]  used_count,
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// ---------------- configuration registers ----------------
	logic [15:0] bb_q;
	logic [6:0]  bib_q;
	logic        cfg_wr;
	logic        cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bb_q  <= 16'd64;
			bib_q <= 7'd64;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_BLOCK_BYTES:   bb_q  <= pwdata[15:0];
				REG_BLOCKS_IN_USE: bib_q <= pwdata[6:0];
			endcase
		end
	end

	// reads: word-aligned addresses only
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (cfg_idx)
				REG_BLOCK_BYTES:   prdata = {16'b0, bb_q};
				REG_BLOCKS_IN_USE: prdata = {25'b0, bib_q};
			endcase
		end
	end

	// active block count, clamped to the pool size
	logic [LIM_W-1:0] bib_ext;
	logic [LIM_W-1:0] lim;
	logic [31:0]      lim32;

	assign bib_ext = LIM_W'(bib_q);
	assign lim     = (bib_ext > LIM_W'(MAX_BLOCKS)) ? LIM_W'(MAX_BLOCKS) : bib_ext;
	assign lim32   = 32'(lim);

	// ---------------- datapath state ----------------
	state_t             state_q, state_d;
	logic [WADDR_W-1:0] addr_q;
	logic [BIT_W-1:0]   bit_q;
	logic [IDX_W-1:0]   idx_q;
	logic [PROD_W-1:0]  prod_q;
	logic [CNT_W-1:0]   cnt_q, cnt_d;

	// result registers
	logic        done_q;
	logic        ok_q;
	logic [21:0] off_q;
	logic [6:0]  used_q;

	// bitmap and divider hookup
	logic              rd_en;
	ram_wr_t           wr;
	logic [WORD_W-1:0] rd_data;
	logic              div_start;
	div_res_t          div_res;

	fbpa_bitmap_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.wr      (wr),
		.rd_data (rd_data)
	);

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (free_offset),
		.divisor  (bb_q),
		.res      (div_res)
	);

	// ---------------- allocate search over one row ----------------
	logic [WORD_W-1:0] free_v;
	logic              row_hit;
	logic [BIT_W-1:0]  hit_pos;
	logic              row_last;

	always_comb begin
		logic [31:0] gidx;
		logic [31:0] next_base;
		free_v = '0;
		for (int b = 0; b < WORD_W; b++) begin
			gidx      = 32'(addr_q) * 32'(WORD_W) + 32'(b);
			free_v[b] = !rd_data[b] && (gidx < lim32);
		end
		hit_pos = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (free_v[b]) begin
				hit_pos = BIT_W'(b);
			end
		end
		row_hit   = |free_v;
		next_base = (32'(addr_q) + 32'd1) * 32'(WORD_W);
		row_last  = (addr_q == WADDR_W'(NUM_WORDS - 1)) || (next_base >= lim32);
	end

	// found block index: row address and bit position
	logic [WADDR_W+BIT_W-1:0] hit_idx;
	assign hit_idx = {addr_q, hit_pos};

	// free target checks
	logic q_in_range;
	assign q_in_range = div_res.quotient < lim32;

	// ---------------- control ----------------
	logic cnt_inc, cnt_dec;
	logic fin, fin_ok, fin_off;
	logic ld_first, ld_next, ld_free, ld_idx;

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		wr.en     = 1'b0;
		wr.addr   = addr_q;
		wr.data   = rd_data;
		div_start = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		fin       = 1'b0;
		fin_ok    = 1'b0;
		fin_off   = 1'b0;
		ld_first  = 1'b0;
		ld_next   = 1'b0;
		ld_free   = 1'b0;
		ld_idx    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (command == CMD_ALLOC) begin
						ld_first = 1'b1;
						state_d  = ST_ARD;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_ARD: begin
				rd_en   = 1'b1;
				state_d = ST_ACHK;
			end
			ST_ACHK: begin
				if (row_hit) begin
					wr.en            = 1'b1;
					wr.data[hit_pos] = 1'b1;
					cnt_inc          = 1'b1;
					ld_idx           = 1'b1;
					state_d          = ST_MUL;
				end else if (row_last) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					ld_next = 1'b1;
					state_d = ST_ARD;
				end
			end
			ST_MUL: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				fin     = 1'b1;
				fin_ok  = 1'b1;
				fin_off = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_res.done) begin
					if (q_in_range) begin
						ld_free = 1'b1;
						state_d = ST_FRD;
					end else begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_FRD: begin
				rd_en   = 1'b1;
				state_d = ST_FCHK;
			end
			ST_FCHK: begin
				fin     = 1'b1;
				state_d = ST_IDLE;
				if (rd_data[bit_q]) begin
					wr.en          = 1'b1;
					wr.data[bit_q] = 1'b0;
					cnt_dec        = 1'b1;
					fin_ok         = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// count never goes below zero
	always_comb begin
		cnt_d = cnt_q;
		if (cnt_inc) begin
			cnt_d = cnt_q + 1'b1;
		end else if (cnt_dec && (cnt_q != '0)) begin
			cnt_d = cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= fin;
		end
	end

	// payload registers, no reset
	logic [31:0] prod32;
	logic [31:0] cnt32;

	assign prod32 = 32'(prod_q);
	assign cnt32  = 32'(cnt_d);

	always_ff @(posedge clk) begin
		if (ld_first) begin
			addr_q <= '0;
		end else if (ld_next) begin
			addr_q <= addr_q + 1'b1;
		end else if (ld_free) begin
			addr_q <= div_res.quotient[BIT_W +: WADDR_W];
		end
		if (ld_free) begin
			bit_q <= div_res.quotient[BIT_W-1:0];
		end
		if (ld_idx) begin
			idx_q <= IDX_W'(hit_idx);
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(idx_q) * PROD_W'(bb_q);
		end
		if (fin) begin
			ok_q   <= fin_ok;
			off_q  <= fin_off ? prod32[21:0] : 22'd0;
			used_q <= cnt32[6:0];
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;
	assign ok           = ok_q;
	assign block_offset = off_q;
	assign used_count   = used_q;

	// ---------------- assertions ----------------
	`FBPA_ASSERT_IMP(a_done_has_request, done_q, $past(busy), "result with no request in flight")
	`FBPA_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy, "accepted request left block idle")
	`FBPA_ASSERT_IMP(a_count_bound, 1'b1, 32'(cnt_q) <= 32'(MAX_BLOCKS), "used count above pool size")
	`FBPA_ASSERT_IMP(a_fail_zero_offset, done_q && !ok_q, off_q == 22'd0, "failed request with offset")
	`FBPA_ASSERT_IMP(a_write_in_check, wr.en, (state_q == ST_ACHK) || (state_q == ST_FCHK),
		"bitmap write outside a check state")

endmodule
